// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the vertex transform top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HVT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HVT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/hvt_pkg.sv =====
// ----------------------------------------------------------------------------
// hvt_pkg
// Widths, stage numbers, codes and types of the vertex transform pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hvt_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAT_N     = 16;
   localparam int IDX_W     = 4;

   localparam int PROD_W = 2 * WORD_BITS;
   localparam int ACC_W  = 2 * WORD_BITS + 2;
   localparam int NUM_W  = ACC_W + FRAC_BITS;
   localparam int QB     = WORD_BITS + 1;
   localparam int CMP_W  = ACC_W + QB;

   localparam int OFF_VAL = IDX_W;
   localparam int OFF_X   = OFF_VAL + WORD_BITS;
   localparam int OFF_Y   = OFF_X + WORD_BITS;
   localparam int OFF_Z   = OFF_Y + WORD_BITS;
   localparam int REQ_DATA_W = ((OFF_Z + WORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((3 * WORD_BITS + 7) / 8) * 8;

   localparam int ST_SNAP = 0;
   localparam int ST_PREP = 4;
   localparam int ST_DIV0 = 5;
   localparam int ST_OUT  = ST_DIV0 + QB + 1;
   localparam int NSTAGE  = ST_OUT + 1;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_XFORM = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_DIV0 = 2'd1,
      STAT_SAT  = 2'd2
   } status_type;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef word_type [MAT_N-1:0] matrix_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [ACC_W-1:0] den;
      logic             neg;
   } lane_type;

   typedef struct packed {
      logic [QB-1:0] q;
      logic          sat;
      logic          neg;
   } quot_type;

endpackage

`default_nettype wire

// ===== sv/hvt_mac.sv =====
// ----------------------------------------------------------------------------
// hvt_mac
// Matrix snapshot, twelve products and four shifted translation terms, two
// adder stages and sign/magnitude preparation of the four row sums for the divider lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hvt_mac (
   input  wire logic                     clock,
   input  wire logic [hvt_pkg::ST_PREP:0] load,
   input  wire hvt_pkg::word_type        vertex_x,
   input  wire hvt_pkg::word_type        vertex_y,
   input  wire hvt_pkg::word_type        vertex_z,
   input  wire hvt_pkg::matrix_type      matrix,
   output hvt_pkg::lane_type [2:0]       lane,
   output logic                          h_zero
);
   import hvt_pkg::*;

   word_type   vx_ff, vy_ff, vz_ff;
   matrix_type m_ff;

   logic signed [PROD_W-1:0] prod_ff [4][3];
   logic signed [PROD_W-1:0] tr_ff   [4];
   logic signed [ACC_W-1:0]  pa_ff   [4];
   logic signed [ACC_W-1:0]  pb_ff   [4];
   logic signed [ACC_W-1:0]  acc_ff  [4];

   lane_type [2:0] lane_ff, lane_in;
   logic           hz_ff, hz_in;
   logic           hneg;
   logic [ACC_W-1:0] hmag;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         vx_ff <= vertex_x;
         vy_ff <= vertex_y;
         vz_ff <= vertex_z;
         m_ff  <= matrix;
      end
      for (int r = 0; r < 4; r++) begin
         if (load[1]) begin
            prod_ff[r][0] <= PROD_W'(m_ff[r])     * PROD_W'(vx_ff);
            prod_ff[r][1] <= PROD_W'(m_ff[4 + r]) * PROD_W'(vy_ff);
            prod_ff[r][2] <= PROD_W'(m_ff[8 + r]) * PROD_W'(vz_ff);
            tr_ff[r]      <= PROD_W'(m_ff[12 + r]) <<< FRAC_BITS;
         end
         if (load[2]) begin
            pa_ff[r] <= ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1]);
            pb_ff[r] <= ACC_W'(prod_ff[r][2]) + ACC_W'(tr_ff[r]);
         end
         if (load[3]) begin
            acc_ff[r] <= pa_ff[r] + pb_ff[r];
         end
      end
      if (load[4]) begin
         lane_ff <= lane_in;
         hz_ff   <= hz_in;
      end
   end

   always_comb begin
      logic             nneg;
      logic [ACC_W-1:0] nmag;
      hneg  = acc_ff[3][ACC_W-1];
      hmag  = hneg ? ACC_W'(-acc_ff[3]) : ACC_W'(acc_ff[3]);
      hz_in = (acc_ff[3] == '0);
      for (int k = 0; k < 3; k++) begin
         nneg = acc_ff[k][ACC_W-1];
         nmag = nneg ? ACC_W'(-acc_ff[k]) : ACC_W'(acc_ff[k]);
         lane_in[k].num = {nmag, {FRAC_BITS{1'b0}}};
         lane_in[k].den = hmag;
         lane_in[k].neg = nneg ^ hneg;
      end
   end

   assign lane   = lane_ff;
   assign h_zero = hz_ff;

endmodule

`default_nettype wire

// ===== sv/hvt_div.sv =====
// ----------------------------------------------------------------------------
// hvt_div
// Pipelined restoring divider lane: an overflow check stage, then one
// quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hvt_div (
   input  wire logic                  clock,
   input  wire logic [hvt_pkg::QB:0]  load,
   input  wire hvt_pkg::lane_type     lane,
   output hvt_pkg::quot_type          quot
);
   import hvt_pkg::*;

   logic [CMP_W-1:0] rem_ff [QB+1];
   logic [ACC_W-1:0] d_ff   [QB+1];
   logic [QB-1:0]    q_ff   [QB+1];
   logic             sat_ff [QB+1];
   logic             neg_ff [QB+1];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         rem_ff[0] <= CMP_W'(lane.num);
         d_ff[0]   <= lane.den;
         q_ff[0]   <= '0;
         sat_ff[0] <= CMP_W'(lane.num) >= (CMP_W'(lane.den) << QB);
         neg_ff[0] <= lane.neg;
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_bit
      logic [CMP_W-1:0] trial;
      logic             take;
      assign trial = CMP_W'(d_ff[j-1]) << (QB - j);
      assign take  = !sat_ff[j-1] && (rem_ff[j-1] >= trial);
      always_ff @(posedge clock) begin
         if (load[j]) begin
            rem_ff[j] <= take ? rem_ff[j-1] - trial : rem_ff[j-1];
            q_ff[j]   <= q_ff[j-1] | (QB'(take) << (QB - j));
            d_ff[j]   <= d_ff[j-1];
            sat_ff[j] <= sat_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   assign quot.q   = q_ff[QB];
   assign quot.sat = sat_ff[QB];
   assign quot.neg = neg_ff[QB];

endmodule

`default_nettype wire

// ===== sv/homogeneous_vertex_transform_top.sv =====
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_top
// Q16.16 4x4 homogeneous vertex transform with perspective divide.
// ----------------------------------------------------------------------------
// Takes one beat per clock while req_tready is high. A write beat (tuser 0)
// stores one column-major matrix element at once and returns nothing; a
// transform beat (tuser 1) returns its projected point after five stages of
// snapshot, multiply, add and sign preparation, an overflow check, one divider
// stage per quotient bit, and the output register. Throughput is one vertex
// per clock while rsp_tready allows; stages advance independently so bubbles
// close up under backpressure.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module homogeneous_vertex_transform_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // element_index, element_value, vertex_x, vertex_y, vertex_z
   input  wire logic [hvt_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // out_x, out_y, out_z
   output logic [hvt_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // status
   output logic [1:0]                             rsp_tuser
);
   import hvt_pkg::*;

   logic [NSTAGE-1:0] valid_ff, load_s;
   matrix_type        mat_ff;
   lane_type [2:0]    lane;
   quot_type [2:0]    quot;
   logic              h_zero;
   logic              hz_ff [ST_DIV0:ST_OUT-1];
   logic              req_take;
   cmd_type           cmd;

   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic [1:0]            stat_ff, stat_in;

   assign cmd      = cmd_type'(req_tuser);
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      load_s[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         load_s[k] = !valid_ff[k] || load_s[k+1];
      end
   end

   assign req_tready = load_s[ST_SNAP];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < MAT_N; i++) begin
            mat_ff[i] <= (i % 5 == 0) ? word_type'(1) <<< FRAC_BITS : '0;
         end
      end else begin
         if (load_s[0]) valid_ff[0] <= req_take && cmd == CMD_XFORM;
         for (int k = 1; k < NSTAGE; k++) begin
            if (load_s[k]) valid_ff[k] <= valid_ff[k-1];
         end
         if (req_take && cmd == CMD_WRITE) begin
            mat_ff[req_tdata[IDX_W-1:0]] <= req_tdata[OFF_VAL +: WORD_BITS];
         end
      end
   end

   hvt_mac u_mac (
      .clock    (clock),
      .load     (load_s[ST_PREP:0]),
      .vertex_x (req_tdata[OFF_X +: WORD_BITS]),
      .vertex_y (req_tdata[OFF_Y +: WORD_BITS]),
      .vertex_z (req_tdata[OFF_Z +: WORD_BITS]),
      .matrix   (mat_ff),
      .lane     (lane),
      .h_zero   (h_zero)
   );

   for (genvar k = 0; k < 3; k++) begin : g_lane
      hvt_div u_div (
         .clock (clock),
         .load  (load_s[ST_OUT-1:ST_DIV0]),
         .lane  (lane[k]),
         .quot  (quot[k])
      );
   end

   always_ff @(posedge clock) begin
      if (load_s[ST_DIV0]) hz_ff[ST_DIV0] <= h_zero;
      for (int k = ST_DIV0 + 1; k < ST_OUT; k++) begin
         if (load_s[k]) hz_ff[k] <= hz_ff[k-1];
      end
      if (load_s[ST_OUT]) begin
         data_ff <= data_in;
         stat_ff <= stat_in;
      end
   end

   always_comb begin
      logic [QB-1:0] lim, mag;
      logic          over, any_over;
      data_in  = '0;
      any_over = 1'b0;
      for (int k = 0; k < 3; k++) begin
         lim  = {1'b0, quot[k].neg, {(WORD_BITS-1){!quot[k].neg}}};
         over = quot[k].sat || (quot[k].q > lim);
         mag  = over ? lim : quot[k].q;
         any_over = any_over | over;
         data_in[k*WORD_BITS +: WORD_BITS] =
            quot[k].neg ? WORD_BITS'(-mag) : WORD_BITS'(mag);
      end
      if (hz_ff[ST_OUT-1]) begin
         data_in = '0;
         stat_in = STAT_DIV0;
      end else if (any_over) begin
         stat_in = STAT_SAT;
      end else begin
         stat_in = STAT_OK;
      end
   end

   assign rsp_tvalid = valid_ff[ST_OUT];
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = stat_ff;

   `HVT_ASSERT_IMPL(a_div0_zero, clock, reset, rsp_tvalid && rsp_tuser == STAT_DIV0, rsp_tdata == '0, "zero h gave nonzero output")
   `HVT_ASSERT_IMPL(a_sat_nonzero, clock, reset, rsp_tvalid && rsp_tuser == STAT_SAT, rsp_tdata != '0, "saturated result is all zero")
   `HVT_ASSERT_NEXT(a_xform_enters, clock, reset, req_take && cmd == CMD_XFORM, valid_ff[0], "transform beat lost at entry")
   `HVT_ASSERT_NEXT(a_write_silent, clock, reset, req_take && cmd == CMD_WRITE, !valid_ff[0], "write beat entered pipeline")

endmodule

`default_nettype wire
